>>> hw/rtl/assert_macros.svh
// Assertion macros used by the deframer sequencer.
// Each macro expects signals named clock and reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Consequent must hold in the same cycle as the antecedent.
`define SLD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define SLD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> hw/rtl/sld_pkg.sv
// Package for the sync/length/checksum deframer: constants, codes and types.
// No dependencies; used by the frame store, check unit, sequencer and top level.
package sld_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int ID_BYTES      = 16;
   localparam int MIN_FRAME     = 6;
   localparam int LEN_W         = 10;
   localparam int OFFSET_W      = 6;
   localparam int MASK_W        = 64;

   localparam logic [7:0]        START_BYTE     = 8'h01;
   localparam logic [7:0]        CLASS_CONFIRM  = 8'hC0;
   localparam logic [7:0]        CLASS_RESPONSE = 8'h80;
   localparam logic [MASK_W-1:0] MASK_RESET     = 64'h3F;

   typedef enum logic [1:0] {
      KIND_BROADCAST = 2'd0,
      KIND_RESPONSE  = 2'd1,
      KIND_CONFIRM   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SUM,
      ST_CKHI,
      ST_CMP,
      ST_EREAD,
      ST_ELOAD,
      ST_EWAIT
   } state_type;

   // What the registered memory read data holds this cycle, for the check unit
   typedef enum logic [1:0] {
      TAG_NONE,
      TAG_SUM,
      TAG_LO
   } tag_type;

   typedef struct packed {
      logic    clear;
      tag_type tag;
   } chk_ctrl_type;

endpackage

>>> hw/rtl/sld_req_if.sv
// Input byte channel of the deframer: valid/ready handshake plus one radio byte.
// No dependencies.
interface sld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/sld_rsp_if.sv
// Result channel of the deframer: valid/ready handshake plus one body byte record.
// No dependencies.
interface sld_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] frame_kind;
   logic [5:0] message_type;
   logic [15:0] message_id;
   logic [5:0] byte_offset;
   logic [7:0] body_byte;
   logic       last_byte;

   modport source (output valid, output frame_kind, output message_type,
                   output message_id, output byte_offset, output body_byte,
                   output last_byte, input ready);
   modport sink   (input valid, input frame_kind, input message_type,
                   input message_id, input byte_offset, input body_byte,
                   input last_byte, output ready);
endinterface

>>> hw/rtl/sld_frame_store.sv
// Frame byte memory: one write port, one read port with registered data.
// Depends on sld_pkg.
module sld_frame_store
   import sld_pkg::*;
#(
   parameter int BUFFER_DEPTH = DEPTH_DEFAULT,
   localparam int AW = $clog2(BUFFER_DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [BUFFER_DEPTH];
   logic [7:0] rd_data_ff;

   // Write the incoming byte
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/sld_check_unit.sv
// Shared checksum unit: accumulates frame bytes and compares with the checksum word.
// Depends on sld_pkg.
module sld_check_unit
   import sld_pkg::*;
(
   input  logic         clock,
   input  chk_ctrl_type ctrl,
   input  logic [7:0]   rd_data,
   output logic         sum_match
);

   logic [15:0] sum_ff;
   logic [7:0]  lo_ff;

   // Accumulate or capture according to the tag of the returning read
   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         sum_ff <= '0;
      end else begin
         unique case (ctrl.tag)
            TAG_SUM:  sum_ff <= sum_ff + {8'd0, rd_data};
            TAG_LO:   lo_ff  <= rd_data;
            TAG_NONE: ;
            default:  ;
         endcase
      end
   end

   // Checksum high byte arrives directly on the read data
   assign sum_match = (sum_ff == {rd_data, lo_ff});

endmodule

>>> hw/rtl/sld_sequencer.sv
// Deframer sequencer: byte intake, header capture, frame check and body emission.
// Depends on sld_pkg, sld_req_if, sld_rsp_if and assert_macros.svh.
`include "assert_macros.svh"
module sld_sequencer
   import sld_pkg::*;
#(
   parameter int BUFFER_DEPTH = DEPTH_DEFAULT,
   localparam int AW = $clog2(BUFFER_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   sld_req_if.sink           req_ch,
   sld_rsp_if.source         rsp_ch,
   input  logic              csr_write_en,
   input  logic [MASK_W-1:0] csr_write_data,
   output logic              mem_we,
   output logic [AW-1:0]     mem_waddr,
   output logic [7:0]        mem_wdata,
   output logic [AW-1:0]     mem_raddr,
   input  logic [7:0]        mem_rdata,
   output chk_ctrl_type      chk_ctrl,
   input  logic              sum_match
);

   state_type         state_ff, state_in;
   logic [AW-1:0]     fill_ff, fill_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     cs_ff, cs_in;
   kind_type          kind_ff, kind_in;
   tag_type           tag_ff, tag_in;
   logic [MASK_W-1:0] mask_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [7:0]  type_ff, lenb_ff, lenr_ff, idlo_ff, idhi_ff;
   logic [1:0]  out_kind_ff;
   logic [5:0]  out_type_ff;
   logic [15:0] out_id_ff;
   logic [5:0]  out_off_ff;
   logic [7:0]  out_byte_ff;
   logic        out_last_ff;

   logic             accept, take, load_out, clear_sum, frame_done, cs_ok, type_ok;
   logic [AW-1:0]    wr_off;
   kind_type         kind_now;
   logic [LEN_W-1:0] fill_w, cs_w;

   assign accept = req_ch.valid && req_ch.ready;

   // Drop a partial frame that has filled the store
   assign wr_off = (fill_ff >= AW'(BUFFER_DEPTH - 1)) ? '0 : fill_ff;
   assign take   = accept && ((wr_off != '0) || (req_ch.rx_byte == START_BYTE));

   // Classify from the stored type byte
   always_comb begin
      if ((type_ff & CLASS_CONFIRM) == CLASS_CONFIRM) begin
         kind_now = KIND_CONFIRM;
      end else if ((type_ff & CLASS_RESPONSE) == CLASS_RESPONSE) begin
         kind_now = KIND_RESPONSE;
      end else begin
         kind_now = KIND_BROADCAST;
      end
   end

   // Completion test and checksum position
   assign fill_w = LEN_W'(fill_ff);
   always_comb begin
      unique case (kind_now)
         KIND_CONFIRM: begin
            frame_done = (fill_w >= LEN_W'(ID_BYTES + 6));
            cs_w       = LEN_W'(ID_BYTES + 4);
         end
         KIND_RESPONSE: begin
            frame_done = (fill_w >= LEN_W'(ID_BYTES + 5)) &&
                         (fill_w >= LEN_W'(ID_BYTES + 7) + LEN_W'(lenr_ff));
            cs_w       = LEN_W'(ID_BYTES + 5) + LEN_W'(lenr_ff);
         end
         default: begin
            frame_done = (fill_w >= LEN_W'(5) + LEN_W'(lenb_ff));
            cs_w       = LEN_W'(3) + LEN_W'(lenb_ff);
         end
      endcase
      frame_done = frame_done && (fill_w >= LEN_W'(MIN_FRAME));
   end

   assign cs_ok   = (cs_w + LEN_W'(1)) < LEN_W'(BUFFER_DEPTH);
   // Types with bit 6 set fall outside the mask for broadcasts and responses
   assign type_ok = !((kind_now != KIND_CONFIRM) && type_ff[6]) && mask_ff[type_ff[5:0]];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (take && (wr_off != '0)) state_in = ST_EVAL;
         ST_EVAL:  state_in = (frame_done && cs_ok) ? ST_SUM : ST_IDLE;
         ST_SUM:   if (idx_ff == cs_ff) state_in = ST_CKHI;
         ST_CKHI:  state_in = ST_CMP;
         ST_CMP:   state_in = (sum_match && type_ok) ? ST_EREAD : ST_IDLE;
         ST_EREAD: state_in = ST_ELOAD;
         ST_ELOAD: state_in = ST_EWAIT;
         ST_EWAIT: begin
            if (rsp_ch.ready) state_in = out_last_ff ? ST_IDLE : ST_ELOAD;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      cs_in        = cs_ff;
      kind_in      = kind_ff;
      tag_in       = TAG_NONE;
      mem_raddr    = idx_ff;
      mem_we       = 1'b0;
      clear_sum    = 1'b0;
      load_out     = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fill_in = take ? (wr_off + AW'(1)) : '0;
               mem_we  = take;
            end
         end
         ST_EVAL: begin
            if (frame_done) begin
               fill_in   = '0;
               cs_in     = AW'(cs_w);
               idx_in    = AW'(1);
               kind_in   = kind_now;
               clear_sum = 1'b1;
            end
         end
         ST_SUM: begin
            tag_in = (idx_ff == cs_ff) ? TAG_LO : TAG_SUM;
            idx_in = idx_ff + AW'(1);
         end
         ST_CKHI: ;
         ST_CMP: idx_in = AW'(2);
         ST_EREAD: ;
         ST_ELOAD: begin
            load_out     = 1'b1;
            rsp_valid_in = 1'b1;
         end
         ST_EWAIT: begin
            if (rsp_ch.ready) begin
               rsp_valid_in = 1'b0;
               idx_in       = idx_ff + AW'(1);
               mem_raddr    = idx_ff + AW'(1);
            end
         end
         default: ;
      endcase
   end

   assign mem_waddr      = wr_off;
   assign mem_wdata      = req_ch.rx_byte;
   assign chk_ctrl.clear = clear_sum;
   assign chk_ctrl.tag   = tag_ff;
   assign req_ch.ready   = (state_ff == ST_IDLE);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         idx_ff       <= '0;
         cs_ff        <= '0;
         kind_ff      <= KIND_BROADCAST;
         tag_ff       <= TAG_NONE;
         rsp_valid_ff <= 1'b0;
         mask_ff      <= MASK_RESET;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         cs_ff        <= cs_in;
         kind_ff      <= kind_in;
         tag_ff       <= tag_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) mask_ff <= csr_write_data;
      end
   end

   // Capture header bytes as they are stored
   always_ff @(posedge clock) begin
      if (mem_we) begin
         if (wr_off == AW'(1))            type_ff <= req_ch.rx_byte;
         if (wr_off == AW'(2))            lenb_ff <= req_ch.rx_byte;
         if (wr_off == AW'(ID_BYTES + 2)) idlo_ff <= req_ch.rx_byte;
         if (wr_off == AW'(ID_BYTES + 3)) idhi_ff <= req_ch.rx_byte;
         if (wr_off == AW'(ID_BYTES + 4)) lenr_ff <= req_ch.rx_byte;
      end
   end

   // Load the result register from the returning body byte
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_kind_ff <= kind_ff;
         out_type_ff <= type_ff[5:0];
         out_id_ff   <= (kind_ff == KIND_BROADCAST) ? 16'd0 : {idhi_ff, idlo_ff};
         out_off_ff  <= OFFSET_W'(idx_ff);
         out_byte_ff <= mem_rdata;
         out_last_ff <= ((idx_ff + AW'(1)) == cs_ff);
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.frame_kind   = out_kind_ff;
   assign rsp_ch.message_type = out_type_ff;
   assign rsp_ch.message_id   = out_id_ff;
   assign rsp_ch.byte_offset  = out_off_ff;
   assign rsp_ch.body_byte    = out_byte_ff;
   assign rsp_ch.last_byte    = out_last_ff;

   `SLD_ASSERT_NOW(a_no_intake_while_emitting, req_ch.ready, !rsp_valid_ff, "byte taken while emitting")
   `SLD_ASSERT_NOW(a_valid_only_in_wait, rsp_valid_ff, state_ff == ST_EWAIT, "result outside wait state")
   `SLD_ASSERT_NOW(a_body_inside_frame, state_ff == ST_ELOAD, idx_ff < cs_ff, "body read past checksum")
   `SLD_ASSERT_NEXT(a_last_ends_frame, rsp_ch.valid && rsp_ch.ready && rsp_ch.last_byte, state_ff == ST_IDLE, "no return to idle after last byte")

endmodule

>>> hw/rtl/sync_length_checksum_deframer.sv
// Sync/length/checksum deframer, top level.
// Input channel req_ch carries one radio byte per transfer; bytes are dropped
// until a 0x01 start byte, then stored until the frame (confirmation, response
// or broadcast, chosen by the type byte) is complete.
// An ordinary byte is taken while idle and then tested for a complete frame
// in the evaluation state. A completing byte then runs the checksum over the
// single memory read port and the shared 16-bit adder, one byte a cycle,
// then compares it with the stored checksum word. A passing frame is emitted
// on rsp_ch as one transfer per body byte, each held until it is taken.
// req_ch.ready is high only while idle, so a stalling receiver holds the
// result register and no new byte is taken until the last body byte is gone.
// csr_write_data loads the 64-bit valid type mask when csr_write_en is high;
// write it only while idle.
// Reset (synchronous) clears the frame fill count, idles the sequencer and sets
// the mask to accept types 0 to 5. No clearing pass is needed.
// Depends on sld_pkg, both channel interfaces and the three submodules.
module sync_length_checksum_deframer
   import sld_pkg::*;
#(
   parameter int BUFFER_DEPTH = DEPTH_DEFAULT,
   localparam int AW = $clog2(BUFFER_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   sld_req_if.sink           req_ch,
   sld_rsp_if.source         rsp_ch,
   input  logic              csr_write_en,
   input  logic [MASK_W-1:0] csr_write_data
);

   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata, mem_rdata;
   chk_ctrl_type  chk_ctrl;
   logic          sum_match;

   // Sequencer
   sld_sequencer #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .mem_we         (mem_we),
      .mem_waddr      (mem_waddr),
      .mem_wdata      (mem_wdata),
      .mem_raddr      (mem_raddr),
      .mem_rdata      (mem_rdata),
      .chk_ctrl       (chk_ctrl),
      .sum_match      (sum_match)
   );

   // Frame store
   sld_frame_store #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Checksum unit
   sld_check_unit u_chk (
      .clock     (clock),
      .ctrl      (chk_ctrl),
      .rd_data   (mem_rdata),
      .sum_match (sum_match)
   );

endmodule
